FILE: hdl/stsc_pkg.sv
// Shared types, token codes and keyword table for the source token scanner.
package stsc_pkg;

    localparam logic [5:0] K_LEFT_PAREN    = 6'd0;
    localparam logic [5:0] K_RIGHT_PAREN   = 6'd1;
    localparam logic [5:0] K_LEFT_BRACE    = 6'd2;
    localparam logic [5:0] K_RIGHT_BRACE   = 6'd3;
    localparam logic [5:0] K_COMMA         = 6'd4;
    localparam logic [5:0] K_DOT           = 6'd5;
    localparam logic [5:0] K_MINUS         = 6'd6;
    localparam logic [5:0] K_PLUS          = 6'd7;
    localparam logic [5:0] K_SEMICOLON     = 6'd8;
    localparam logic [5:0] K_SLASH         = 6'd9;
    localparam logic [5:0] K_STAR          = 6'd10;
    localparam logic [5:0] K_BANG          = 6'd11;
    localparam logic [5:0] K_BANG_EQUAL    = 6'd12;
    localparam logic [5:0] K_EQUAL         = 6'd13;
    localparam logic [5:0] K_EQUAL_EQUAL   = 6'd14;
    localparam logic [5:0] K_GREATER       = 6'd15;
    localparam logic [5:0] K_GREATER_EQUAL = 6'd16;
    localparam logic [5:0] K_LESS          = 6'd17;
    localparam logic [5:0] K_LESS_EQUAL    = 6'd18;
    localparam logic [5:0] K_IDENTIFIER    = 6'd19;
    localparam logic [5:0] K_STRING        = 6'd20;
    localparam logic [5:0] K_NUMBER        = 6'd21;
    localparam logic [5:0] K_FIRST_KEYWORD = 6'd22;
    localparam logic [5:0] K_END           = 6'd38;

    localparam logic [1:0] E_NONE         = 2'd0;
    localparam logic [1:0] E_UNEXPECTED   = 2'd1;
    localparam logic [1:0] E_UNTERMINATED = 2'd2;

    localparam int SLOTS       = 3;
    localparam int KEYWORDS    = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [47:0] KEYWORD_TEXT [KEYWORDS] = '{
        48'h616e64,       48'h636c617373,   48'h656c7365,     48'h66616c7365,
        48'h66756e,       48'h666f72,       48'h6966,         48'h6e696c,
        48'h6f72,         48'h7072696e74,   48'h72657475726e, 48'h7375706572,
        48'h74686973,     48'h74727565,     48'h766172,       48'h7768696c65
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] start;
        logic [31:0] len;
    } res_t;

    typedef struct packed {
        res_t [SLOTS-1:0] slot;
        logic [1:0]       count;
        logic [23:0]      line;
    } bundle_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

    function automatic logic [5:0] word_kind(input logic [47:0] text, input logic too_long);
        logic [5:0] kind;
        kind = K_IDENTIFIER;
        for (int i = 0; i < KEYWORDS; i++)
        begin
            if (!too_long && text == KEYWORD_TEXT[i])
            begin
                kind = K_FIRST_KEYWORD + 6'(i);
            end
        end
        return kind;
    endfunction

endpackage

FILE: hdl/stsc_front.sv
// Scanner front end: tracks the lexer state and builds the results of each byte.
module stsc_front #(
    parameter int OFFSET_WIDTH = 32,
    parameter int LINE_WIDTH   = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic              mode,
    input  logic [7:0]        src_byte,
    output logic              q_push,
    output stsc_pkg::bundle_t bundle
);
    import stsc_pkg::*;

    localparam int OW = OFFSET_WIDTH;
    localparam int LW = LINE_WIDTH;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_LESS    = 8'h3c;
    localparam logic [7:0] CH_GREATER = 8'h3e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0b;
    localparam logic [7:0] CH_FFEED   = 8'h0c;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SLASH,
        PH_BANG,
        PH_EQUAL,
        PH_LESS,
        PH_GREATER,
        PH_COMMENT,
        PH_STRING,
        PH_INT,
        PH_INT_DOT,
        PH_FRAC,
        PH_WORD
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [OW-1:0]   offset_reg, offset_next;
    logic [OW-1:0]   start_reg, start_next;
    logic [LW-1:0]   line_reg, line_next;
    logic [47:0]     word_reg, word_next;
    logic            long_reg, long_next;

    logic [OW:0]     pos1;
    logic [OW:0]     start1;
    logic [OW-1:0]   dot;
    logic [OW:0]     span_begin;
    logic [OW:0]     span_end;
    logic [31:0]     span;
    logic [LW-1:0]   line_up;
    logic            is_digit;
    logic            is_letter;
    logic            op_phase;
    logic [5:0]      single_kind;
    logic [5:0]      pair_kind;

    logic            st_valid;
    res_t            st_res;
    phase_t          st_phase;
    logic            st_nl;
    logic            st_word;

    logic [1:0]      f_n;
    res_t            f0;
    res_t            f1;

    logic            do_flush;
    logic            take_start;
    logic            tail_valid;
    res_t            tail;
    logic [1:0]      n_flush;

    function automatic logic [31:0] lo32(input logic [OW:0] x);
        logic [OW+32:0] w;
        w = {32'b0, x};
        return w[31:0];
    endfunction

    function automatic logic [31:0] span_len(input logic [OW:0] e, input logic [OW:0] b);
        logic [OW+32:0] d;
        d = {32'b0, e - b};
        if (e <= b)
        begin
            return '0;
        end
        if (d > (OW+33)'(33'h0ffffffff))
        begin
            return '1;
        end
        return d[31:0];
    endfunction

    function automatic logic [23:0] line24(input logic [LW-1:0] x);
        logic [LW+23:0] w;
        w = {24'b0, x};
        return w[23:0];
    endfunction

    assign pos1      = {1'b0, offset_reg};
    assign start1    = {1'b0, start_reg} + (OW+1)'(1);
    assign dot       = (offset_reg == '0) ? '0 : offset_reg - OW'(1);
    assign line_up   = (line_reg == '1) ? line_reg : line_reg + LW'(1);
    assign is_digit  = (src_byte >= CH_0) && (src_byte <= CH_9);
    assign is_letter = ((src_byte >= CH_LOWER_A) && (src_byte <= CH_LOWER_Z))
                    || ((src_byte >= CH_UPPER_A) && (src_byte <= CH_UPPER_Z));
    assign op_phase  = (phase_reg == PH_BANG) || (phase_reg == PH_EQUAL)
                    || (phase_reg == PH_LESS) || (phase_reg == PH_GREATER);

    always_comb
    begin
        case (phase_reg)
            PH_BANG:
            begin
                single_kind = K_BANG;
                pair_kind   = K_BANG_EQUAL;
            end
            PH_EQUAL:
            begin
                single_kind = K_EQUAL;
                pair_kind   = K_EQUAL_EQUAL;
            end
            PH_GREATER:
            begin
                single_kind = K_GREATER;
                pair_kind   = K_GREATER_EQUAL;
            end
            default:
            begin
                single_kind = K_LESS;
                pair_kind   = K_LESS_EQUAL;
            end
        endcase
    end

    // A single subtractor serves the pending token, a two-character operator and a string.
    always_comb
    begin
        span_begin = (phase_reg == PH_STRING) ? start1 : {1'b0, start_reg};
        if (phase_reg == PH_INT_DOT)
        begin
            span_end = {1'b0, dot};
        end
        else if (op_phase && !mode && src_byte == CH_EQUAL)
        begin
            span_end = pos1 + (OW+1)'(1);
        end
        else
        begin
            span_end = pos1;
        end
        span = span_len(span_end, span_begin);
    end

    always_comb
    begin
        f_n = 2'd0;
        f0  = '{kind: K_NUMBER, err: E_NONE, start: lo32({1'b0, start_reg}), len: span};
        f1  = '{kind: K_DOT, err: E_NONE, start: lo32({1'b0, dot}), len: 32'd1};
        case (phase_reg)
            PH_SLASH:
            begin
                f_n     = 2'd1;
                f0.kind = K_SLASH;
            end
            PH_BANG, PH_EQUAL, PH_LESS, PH_GREATER:
            begin
                f_n     = 2'd1;
                f0.kind = single_kind;
            end
            PH_INT, PH_FRAC:
            begin
                f_n = 2'd1;
            end
            PH_INT_DOT:
            begin
                f_n = 2'd2;
            end
            PH_WORD:
            begin
                f_n     = 2'd1;
                f0.kind = word_kind(word_reg, long_reg);
            end
            PH_STRING:
            begin
                f_n      = 2'd1;
                f0.kind  = '0;
                f0.err   = E_UNTERMINATED;
                f0.start = lo32(start1);
            end
            default:
            begin
                f_n = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        st_valid = 1'b0;
        st_res   = '{kind: '0, err: E_NONE, start: lo32(pos1), len: 32'd1};
        st_phase = PH_IDLE;
        st_nl    = 1'b0;
        st_word  = 1'b0;
        case (src_byte)
            CH_LPAREN:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_LEFT_PAREN;
            end
            CH_RPAREN:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_RIGHT_PAREN;
            end
            CH_LBRACE:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_LEFT_BRACE;
            end
            CH_RBRACE:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_RIGHT_BRACE;
            end
            CH_COMMA:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_COMMA;
            end
            CH_DOT:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_DOT;
            end
            CH_MINUS:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_MINUS;
            end
            CH_PLUS:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_PLUS;
            end
            CH_SEMI:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_SEMICOLON;
            end
            CH_STAR:
            begin
                st_valid    = 1'b1;
                st_res.kind = K_STAR;
            end
            CH_BANG:
            begin
                st_phase = PH_BANG;
            end
            CH_EQUAL:
            begin
                st_phase = PH_EQUAL;
            end
            CH_LESS:
            begin
                st_phase = PH_LESS;
            end
            CH_GREATER:
            begin
                st_phase = PH_GREATER;
            end
            CH_SLASH:
            begin
                st_phase = PH_SLASH;
            end
            CH_NEWLINE:
            begin
                st_nl = 1'b1;
            end
            CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR:
            begin
                st_phase = PH_IDLE;
            end
            CH_QUOTE:
            begin
                st_phase = PH_STRING;
            end
            default:
            begin
                if (is_digit)
                begin
                    st_phase = PH_INT;
                end
                else if (is_letter)
                begin
                    st_phase = PH_WORD;
                    st_word  = 1'b1;
                end
                else
                begin
                    st_valid   = 1'b1;
                    st_res.err = E_UNEXPECTED;
                end
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        line_next   = line_reg;
        word_next   = word_reg;
        long_next   = long_reg;
        do_flush    = 1'b0;
        take_start  = 1'b0;
        tail_valid  = 1'b0;
        tail        = st_res;
        if (mode)
        begin
            do_flush    = 1'b1;
            tail_valid  = 1'b1;
            tail        = '{kind: K_END, err: E_NONE, start: lo32(pos1), len: 32'd0};
            phase_next  = PH_IDLE;
            offset_next = '0;
            start_next  = '0;
            line_next   = LW'(1);
            word_next   = '0;
            long_next   = 1'b0;
        end
        else
        begin
            offset_next = (offset_reg == '1) ? offset_reg : offset_reg + OW'(1);
            case (phase_reg)
                PH_BANG, PH_EQUAL, PH_LESS, PH_GREATER:
                begin
                    if (src_byte == CH_EQUAL)
                    begin
                        tail_valid = 1'b1;
                        tail       = '{kind: pair_kind, err: E_NONE,
                                       start: lo32({1'b0, start_reg}), len: span};
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        take_start = 1'b1;
                    end
                end
                PH_SLASH:
                begin
                    if (src_byte == CH_SLASH)
                    begin
                        phase_next = PH_COMMENT;
                    end
                    else
                    begin
                        take_start = 1'b1;
                    end
                end
                PH_COMMENT:
                begin
                    if (src_byte == CH_NEWLINE)
                    begin
                        line_next  = line_up;
                        phase_next = PH_IDLE;
                    end
                end
                PH_STRING:
                begin
                    if (src_byte == CH_QUOTE)
                    begin
                        tail_valid = 1'b1;
                        tail       = '{kind: K_STRING, err: E_NONE,
                                       start: lo32(start1), len: span};
                        phase_next = PH_IDLE;
                    end
                    else if (src_byte == CH_NEWLINE)
                    begin
                        line_next = line_up;
                    end
                end
                PH_INT:
                begin
                    if (src_byte == CH_DOT)
                    begin
                        phase_next = PH_INT_DOT;
                    end
                    else if (!is_digit)
                    begin
                        take_start = 1'b1;
                    end
                end
                PH_INT_DOT:
                begin
                    if (is_digit)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        take_start = 1'b1;
                    end
                end
                PH_FRAC:
                begin
                    if (!is_digit)
                    begin
                        take_start = 1'b1;
                    end
                end
                PH_WORD:
                begin
                    if (is_digit || is_letter)
                    begin
                        if (word_reg[47:40] != 8'd0)
                        begin
                            long_next = 1'b1;
                        end
                        word_next = {word_reg[39:0], src_byte};
                    end
                    else
                    begin
                        take_start = 1'b1;
                    end
                end
                default:
                begin
                    take_start = 1'b1;
                end
            endcase
            if (take_start)
            begin
                do_flush   = 1'b1;
                tail_valid = st_valid;
                tail       = st_res;
                phase_next = st_phase;
                start_next = offset_reg;
                if (st_nl)
                begin
                    line_next = line_up;
                end
                if (st_word)
                begin
                    word_next = {40'b0, src_byte};
                    long_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        n_flush = do_flush ? f_n : 2'd0;
        bundle  = '0;
        case (n_flush)
            2'd0:
            begin
                bundle.slot[0] = tail;
            end
            2'd1:
            begin
                bundle.slot[0] = f0;
                bundle.slot[1] = tail;
            end
            default:
            begin
                bundle.slot[0] = f0;
                bundle.slot[1] = f1;
                bundle.slot[2] = tail;
            end
        endcase
        bundle.count = n_flush + {1'b0, tail_valid};
        bundle.line  = line24(line_reg);
    end

    assign q_push = in_accept && (bundle.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            offset_reg <= '0;
            start_reg  <= '0;
            line_reg   <= LW'(1);
            word_reg   <= '0;
            long_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            line_reg   <= line_next;
            word_reg   <= word_next;
            long_reg   <= long_next;
        end
    end

endmodule

FILE: hdl/stsc_queue.sv
// Short queue of result bundles between the scanner front end and the back end.
module stsc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  stsc_pkg::bundle_t wr_data,
    input  logic              rd_en,
    output stsc_pkg::bundle_t rd_data,
    output stsc_pkg::qstat_t  status
);
    import stsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t            store [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && status.valid;
    assign rd_data      = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/stsc_back.sv
// Scanner back end: hands the results of each bundle out one word at a time.
module stsc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  stsc_pkg::qstat_t  q_stat,
    input  stsc_pkg::bundle_t head,
    output logic              deq,
    input  logic              pop,
    output logic              empty,
    output logic [5:0]        token_kind,
    output logic [1:0]        error_kind,
    output logic [31:0]       start_offset,
    output logic [31:0]       lexeme_length,
    output logic [23:0]       line_number,
    output logic              last
);
    import stsc_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  sel_reg, sel_next;
    res_t        res_reg;
    logic [23:0] line_reg;
    logic        last_reg;
    logic        load;
    logic        final_slot;
    res_t        cur;

    assign load       = q_stat.valid && (!valid_reg || pop);
    assign final_slot = (sel_reg == head.count - 2'd1);
    assign cur        = head.slot[sel_reg];
    assign deq        = load && final_slot;
    assign empty      = !valid_reg;

    assign token_kind    = res_reg.kind;
    assign error_kind    = res_reg.err;
    assign start_offset  = res_reg.start;
    assign lexeme_length = res_reg.len;
    assign line_number   = line_reg;
    assign last          = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sel_next   = final_slot ? 2'd0 : sel_reg + 2'd1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= cur;
            line_reg <= head.line;
            last_reg <= final_slot;
        end
    end

endmodule

FILE: hdl/source_token_scanner.sv
// Streaming source scanner: one source byte per word in, tokens out.
// A byte is accepted every cycle while the two-entry bundle queue has room.
// Its token words pass through the bundle queue and are then loaded into the output register.
// Results leave one word per cycle while pop is asserted, so a byte giving k tokens yields k output words.
// Reset is asynchronous: offset zero, line one, queue and output emptied.
module source_token_scanner #(
    parameter int OFFSET_WIDTH = 32,
    parameter int LINE_WIDTH   = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  src_byte,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  token_kind,
    output logic [1:0]  error_kind,
    output logic [31:0] start_offset,
    output logic [31:0] lexeme_length,
    output logic [23:0] line_number,
    output logic        last
);
    import stsc_pkg::*;

    logic     in_accept;
    logic     front_push;
    bundle_t  front_bundle;
    bundle_t  head;
    qstat_t   q_stat;
    logic     deq;

    assign full      = q_stat.full;
    assign in_accept = push && !q_stat.full;

    stsc_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .mode      (mode),
        .src_byte  (src_byte),
        .q_push    (front_push),
        .bundle    (front_bundle)
    );

    stsc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_bundle),
        .rd_en   (deq),
        .rd_data (head),
        .status  (q_stat)
    );

    stsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head          (head),
        .deq           (deq),
        .pop           (pop),
        .empty         (empty),
        .token_kind    (token_kind),
        .error_kind    (error_kind),
        .start_offset  (start_offset),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last          (last)
    );

    a_head_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.valid |-> (head.count != 2'd0))
        else $error("Queue head holds a bundle with no results.");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode) |->
            (front_push && front_bundle.slot[front_bundle.count - 2'd1].kind == K_END))
        else $error("End of source did not close its bundle with an END token.");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (front_push && !q_stat.valid) |=> q_stat.valid)
        else $error("A pushed bundle did not reach the queue head.");

endmodule
